[design/mrr_pkg.sv]
// shared constants, types and helper functions for the ranged mt19937 generator
// no dependencies
package mrr_pkg;

    localparam int TABLE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int IDX_W        = $clog2(TABLE_WORDS + 1);

    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(TABLE_WORDS - 1);
    localparam logic [IDX_W-1:0] IDX_FULL  = IDX_W'(TABLE_WORDS);
    localparam logic [IDX_W-1:0] IDX_OFS   = IDX_W'(TWIST_OFFSET);
    localparam logic [IDX_W-1:0] IDX_WRAP  = IDX_W'(TABLE_WORDS - TWIST_OFFSET);

    localparam logic [31:0] RESET_SEED   = 32'd4357;
    localparam logic [31:0] SEED_MULT    = 32'd69069;
    localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc60000;

    localparam logic [2:0]  ADDR_SEED    = 3'd0;

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] span;
        logic        equal;
    } item_t;

    typedef enum logic [2:0] {
        TB_FILL,
        TB_IDLE,
        TB_LOAD,
        TB_PRIME,
        TB_CALC,
        TB_FETCH,
        TB_WAIT
    } tbl_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WORD,
        BK_DIV,
        BK_PUT
    } bk_state_t;

    function automatic logic [31:0] temper(input logic [31:0] y_in);
        logic [31:0] y;
        y = y_in;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic [IDX_W-1:0] nxt_idx(input logic [IDX_W-1:0] k);
        return (k == IDX_LAST) ? '0 : k + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] far_idx(input logic [IDX_W-1:0] k);
        return (k >= IDX_WRAP) ? k - IDX_WRAP : k + IDX_OFS;
    endfunction

endpackage

[design/mrr_front.sv]
// front end: input handshake, item classification and a two-entry queue
// depends on mrr_pkg
module mrr_front
    import mrr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] low_bound,
    input  logic [31:0] high_bound,
    input  logic        hold,
    input  logic        pop,
    output logic        ent_valid,
    output item_t       ent
);

    item_t       q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    item_t       new_item;

    assign in_stall  = hold || (cnt_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign ent_valid = (cnt_reg != 2'd0);
    assign ent       = q_reg[rd_ptr_reg];

    // span wraps, so high below low still gives a nonzero span
    always_comb
    begin
        new_item.lo    = low_bound;
        new_item.span  = high_bound - low_bound;
        new_item.equal = (low_bound == high_bound);
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue count out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != 2'd0)
        else $error("pop from empty queue");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> in_stall)
        else $error("full queue not stalling");

endmodule

[design/mrr_table.sv]
// state table memory with seeding sweep, in-place twist sequencer and tempered fetch
// depends on mrr_pkg
module mrr_table
    import mrr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fill_start,
    input  logic [31:0] fill_seed,
    input  logic        word_req,
    output logic        word_valid,
    output logic [31:0] word,
    output logic        filling
);

    logic [31:0]      mem [TABLE_WORDS];
    tbl_state_t       state_reg, state_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]      fill_word_reg, fill_word_next;
    logic [31:0]      cur_reg, cur_next;
    logic [31:0]      rd_a_reg, rd_b_reg;
    logic [IDX_W-1:0] rd_a_addr, rd_b_addr, waddr;
    logic [31:0]      wdata;
    logic             we;
    logic [31:0]      fill_prod;
    logic [31:0]      tw_y, tw_v;

    assign fill_prod = fill_word_reg * SEED_MULT;
    assign tw_y      = {cur_reg[31], rd_a_reg[30:0]};
    assign tw_v      = rd_b_reg ^ (tw_y >> 1) ^ (tw_y[0] ? TWIST_MATRIX : 32'd0);
    assign word      = temper(rd_a_reg);
    assign filling   = (state_reg == TB_FILL);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            TB_FILL:  if (k_reg == IDX_LAST) state_next = TB_IDLE;
            TB_IDLE:
            begin
                if (word_req)
                begin
                    state_next = (idx_reg >= IDX_FULL) ? TB_LOAD : TB_FETCH;
                end
            end
            TB_LOAD:  state_next = TB_PRIME;
            TB_PRIME: state_next = TB_CALC;
            TB_CALC:  if (k_reg == IDX_LAST) state_next = TB_FETCH;
            TB_FETCH: state_next = TB_WAIT;
            TB_WAIT:  state_next = TB_IDLE;
            default:  state_next = TB_IDLE;
        endcase
        if (fill_start)
        begin
            state_next = TB_FILL;
        end
    end

    // memory control and outputs
    always_comb
    begin
        we         = 1'b0;
        waddr      = k_reg;
        wdata      = tw_v;
        rd_a_addr  = '0;
        rd_b_addr  = '0;
        word_valid = 1'b0;
        unique case (state_reg)
            TB_FILL:
            begin
                we    = 1'b1;
                wdata = fill_word_reg;
            end
            TB_LOAD:  rd_a_addr = '0;
            TB_PRIME:
            begin
                rd_a_addr = nxt_idx('0);
                rd_b_addr = far_idx('0);
            end
            TB_CALC:
            begin
                we        = 1'b1;
                rd_a_addr = nxt_idx(nxt_idx(k_reg));
                rd_b_addr = far_idx(nxt_idx(k_reg));
            end
            TB_FETCH: rd_a_addr = idx_reg;
            TB_WAIT:  word_valid = 1'b1;
            default:  we = 1'b0;
        endcase
    end

    // counters and data registers
    always_comb
    begin
        k_next         = k_reg;
        idx_next       = idx_reg;
        fill_word_next = fill_word_reg;
        cur_next       = cur_reg;
        unique case (state_reg)
            TB_FILL:
            begin
                k_next         = nxt_idx(k_reg);
                fill_word_next = fill_prod;
            end
            TB_PRIME: cur_next = rd_a_reg;
            TB_CALC:
            begin
                cur_next = rd_a_reg;
                k_next   = nxt_idx(k_reg);
                if (k_reg == IDX_LAST)
                begin
                    idx_next = '0;
                end
            end
            TB_WAIT:  idx_next = idx_reg + 1'b1;
            default:  k_next = k_reg;
        endcase
        if (fill_start)
        begin
            k_next         = '0;
            idx_next       = IDX_FULL;
            fill_word_next = fill_seed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TB_FILL;
            k_reg         <= '0;
            idx_reg       <= IDX_FULL;
            fill_word_reg <= RESET_SEED;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            idx_reg       <= idx_next;
            fill_word_reg <= fill_word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_FULL)
        else $error("word index beyond table");

    a_fetch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == TB_FETCH |-> idx_reg < IDX_FULL)
        else $error("fetch from used-up table");

    a_twist_resets_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == TB_CALC && k_reg == IDX_LAST && !fill_start) |=> idx_reg == '0)
        else $error("twist did not restart index");

endmodule

[design/mrr_mod.sv]
// iterative unsigned remainder, one quotient bit per cycle
// depends on mrr_pkg
module mrr_mod
    import mrr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] rem
);

    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvd_reg, dvd_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] trial;

    assign trial = {rem_reg[31:0], dvd_reg[31]};
    assign done  = done_reg;
    assign rem   = rem_reg[31:0];

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            dvd_next = dividend;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next = (trial >= {1'b0, dvs_reg}) ? trial - {1'b0, dvs_reg} : trial;
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 5'd31)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg)
        else $error("remainder done while still running");

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < {1'b0, dvs_reg})
        else $error("remainder not below divisor");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> !start)
        else $error("start while busy");

endmodule

[design/mt19937_ranged_integer_rng_unit.sv]
// top level of the ranged mt19937 generator: config port, back-end sequencer, output register
// depends on mrr_pkg, mrr_front, mrr_table, mrr_mod
//
// usage
//   input channel: in_valid / in_stall carry one request item (low_bound, high_bound)
//   output channel: out_valid / out_stall carry one result item (value) per request
//   an item moves at a clock edge where valid is high and stall is low
//   the front queues up to two requests, so a new item is taken while a result waits
// request handling
//   equal bounds: value is low_bound, loaded from the queue into the output register
//   other requests: queue pop, table fetch, bit-serial remainder unit, then the
//   remainder plus low_bound is handed on and loaded into the output register;
//   the back end takes the next request from the queue only after that load
//   every 624th generated word first runs the twist sweep (load, prime, calc)
// reset and seeding
//   after reset the table is refilled from seed 4357, one word a cycle through all
//   624 words, with in_stall held high; a write to the seed register at address 0
//   starts the same sweep from the new seed
// stalls
//   when out_stall is high the result is held in the output register and the
//   back end waits to load; the front keeps queueing until its two entries are full
module mt19937_ranged_integer_rng_unit
    import mrr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] low_bound,
    input  logic [31:0] high_bound,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    bk_state_t   state_reg, state_next;
    logic [31:0] seed_reg;
    logic [31:0] lo_reg, lo_next;
    logic [31:0] span_reg, span_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] value_reg, value_next;

    logic        seed_wr;
    logic        pop;
    logic        ent_valid;
    item_t       ent;
    logic        word_req, word_valid, filling;
    logic [31:0] word;
    logic        div_start, div_done;
    logic [31:0] div_rem;
    logic        out_free;
    logic        out_load;
    logic [31:0] out_data;

    // config port: single seed register
    assign pready  = 1'b1;
    assign prdata  = seed_reg;
    assign seed_wr = psel && penable && pwrite && (paddr == ADDR_SEED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= RESET_SEED;
        end
        else if (seed_wr)
        begin
            seed_reg <= pwdata;
        end
    end

    mrr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .low_bound  (low_bound),
        .high_bound (high_bound),
        .hold       (filling),
        .pop        (pop),
        .ent_valid  (ent_valid),
        .ent        (ent)
    );

    mrr_table u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .fill_start (seed_wr),
        .fill_seed  (pwdata),
        .word_req   (word_req),
        .word_valid (word_valid),
        .word       (word),
        .filling    (filling)
    );

    mrr_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (word),
        .divisor  (span_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    // output register frees up when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;

    // back-end next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (ent_valid && out_free && !ent.equal)
                begin
                    state_next = BK_WORD;
                end
            end
            BK_WORD: if (word_valid) state_next = BK_DIV;
            BK_DIV:  if (div_done) state_next = BK_PUT;
            BK_PUT:  if (out_free) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // back-end outputs
    always_comb
    begin
        pop       = 1'b0;
        word_req  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        out_data  = div_rem + lo_reg;
        lo_next   = lo_reg;
        span_next = span_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (ent_valid && out_free)
                begin
                    pop       = 1'b1;
                    lo_next   = ent.lo;
                    span_next = ent.span;
                    if (ent.equal)
                    begin
                        // equal bounds pass straight through, state untouched
                        out_load = 1'b1;
                        out_data = ent.lo;
                    end
                end
            end
            BK_WORD:
            begin
                word_req  = 1'b1;
                div_start = word_valid;
            end
            BK_DIV:  out_load = 1'b0;
            BK_PUT:  out_load = out_free;
            default: out_load = 1'b0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        value_next     = value_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            value_next     = out_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        span_reg  <= span_next;
        value_reg <= value_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    a_fill_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        filling |-> in_stall)
        else $error("input accepted during table fill");

    a_word_when_asked: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid |-> state_reg == BK_WORD)
        else $error("table word without request");

    a_div_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == BK_DIV)
        else $error("remainder done outside divide state");

    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output overwritten while held");

endmodule

[dv/tb.sv]
// self-checking testbench for mt19937_ranged_integer_rng_unit
// depends on mrr_pkg and the design files; drives requests, seeds and checks each value
`timescale 1ns / 1ps

module tb;
    import mrr_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] low_bound;
    logic [31:0] high_bound;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] value;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mt19937_ranged_integer_rng_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .low_bound  (low_bound),
        .high_bound (high_bound),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // generator model state
    logic [31:0] mt_words [TABLE_WORDS];
    int unsigned mt_pos;

    // expected values, oldest first
    logic [31:0] pending_values [$];

    int unsigned errors;
    int unsigned cycles;
    bit          calm;      // no idling in the final stretch
    bit          hold_off;  // long receiver hold-off requested

    localparam int unsigned CYCLE_LIMIT = 1500000;

    typedef struct {
        logic [31:0] lo;
        logic [31:0] hi;
        bit          known;   // expected value typed in
        logic [31:0] want;
    } req_row_t;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // seeding by the old multiplier recurrence
    function automatic void seed_table(input logic [31:0] seed);
        mt_words[0] = seed;
        for (int k = 1; k < TABLE_WORDS; k++)
            mt_words[k] = mt_words[k-1] * 32'd69069;
        mt_pos = TABLE_WORDS;
    endfunction

    function automatic void twist_words();
        logic [31:0] y;
        logic [31:0] v;
        for (int k = 0; k < TABLE_WORDS; k++)
        begin
            y = (mt_words[k] & 32'h80000000) | (mt_words[(k+1) % TABLE_WORDS] & 32'h7fffffff);
            v = mt_words[(k + TWIST_OFFSET) % TABLE_WORDS] ^ (y >> 1);
            if (y[0])
                v = v ^ 32'h9908b0df;
            mt_words[k] = v;
        end
        mt_pos = 0;
    endfunction

    // next ranged value; equal bounds leave the table alone
    function automatic logic [31:0] next_ranged(input logic [31:0] lo, input logic [31:0] hi);
        logic [31:0] y;
        logic [31:0] span;
        if (lo == hi)
            return lo;
        if (mt_pos >= TABLE_WORDS)
            twist_words();
        y = mt_words[mt_pos];
        mt_pos++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & 32'h9d2c5680);
        y = y ^ ((y << 15) & 32'hefc60000);
        y = y ^ (y >> 18);
        span = hi - lo;
        return (y % span) + lo;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** mt19937_ranged_integer_rng_unit: FAILED **");
            $finish;
        end
    end

    // result checker, sampled at the accepting edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_values.size() == 0)
                report_mismatch($sformatf("unexpected value %h", value));
            else
            begin
                if (value !== pending_values[0])
                    report_mismatch($sformatf("value %h, wanted %h", value, pending_values[0]));
                void'(pending_values.pop_front());
            end
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (2000) @(posedge clk);
                hold_off = 1'b0;
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 7);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // one register write: setup then access
    task automatic write_seed(input logic [31:0] seed);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SEED;
        pwdata  <= seed;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        seed_table(seed);
    endtask

    // wait until every value is back, then let the block settle
    task automatic drain();
        while (pending_values.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // offer one request, holding it until taken; random gaps before it
    task automatic send_request(input logic [31:0] lo, input logic [31:0] hi,
                                input bit known, input logic [31:0] want);
        logic [31:0] predicted;
        int n;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid   <= 1'b1;
        low_bound  <= lo;
        high_bound <= hi;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = next_ranged(lo, hi);
        pending_values.push_back(known ? want : predicted);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'hffffffff;
            3: return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    task automatic random_phase(input int count);
        logic [31:0] lo;
        logic [31:0] hi;
        for (int i = 0; i < count; i++)
        begin
            lo = rand_word();
            case ($urandom_range(0, 9))
                0: hi = lo;
                1: hi = lo + $urandom_range(1, 4);
                2, 3: hi = lo + $urandom_range(1, 1000);
                4: hi = lo - $urandom_range(1, 100);
                default: hi = rand_word();
            endcase
            send_request(lo, hi, 1'b0, 32'h0);
        end
        in_valid <= 1'b0;
    endtask

    req_row_t directed_rows [16] = '{
        // equal bounds return low unchanged
        '{32'h0,        32'h0,        1'b1, 32'h0},
        '{32'h80000000, 32'h80000000, 1'b1, 32'h80000000},
        '{32'h7fffffff, 32'h7fffffff, 1'b1, 32'h7fffffff},
        '{32'hffffffff, 32'hffffffff, 1'b1, 32'hffffffff},
        // span of one always gives low
        '{32'h00000005, 32'h00000006, 1'b1, 32'h00000005},
        '{32'h7fffffff, 32'h80000000, 1'b1, 32'h7fffffff},
        '{32'hffffffff, 32'h00000000, 1'b1, 32'hffffffff},
        // full ranges, high below low and other mixed spans
        '{32'h80000000, 32'h7fffffff, 1'b0, 32'h0},
        '{32'h7fffffff, 32'h80000000 + 32'd1, 1'b0, 32'h0},
        '{32'h00000000, 32'hffffffff, 1'b0, 32'h0},
        '{32'h00000010, 32'h00000000, 1'b0, 32'h0},
        '{32'hffffffff, 32'hfffffffe, 1'b0, 32'h0},
        '{32'h00000000, 32'h00000064, 1'b0, 32'h0},
        '{32'hffffff9c, 32'h00000064, 1'b0, 32'h0},
        '{32'h12345678, 32'h12345679, 1'b1, 32'h12345678},
        '{32'h55555555, 32'haaaaaaaa, 1'b0, 32'h0}
    };

    initial
    begin
        errors     = 0;
        cycles     = 0;
        calm       = 1'b0;
        hold_off   = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        low_bound  = '0;
        high_bound = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        seed_table(32'd4357);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows from the reset seed
        foreach (directed_rows[i])
            send_request(directed_rows[i].lo, directed_rows[i].hi,
                         directed_rows[i].known, directed_rows[i].want);
        in_valid <= 1'b0;
        drain();

        // zero seed: every generated word is zero
        write_seed(32'h0);
        random_phase(60);
        drain();

        // long receiver hold-off while requests keep coming
        write_seed(32'hffffffff);
        hold_off = 1'b1;
        random_phase(250);
        drain();

        write_seed($urandom());
        random_phase(700);
        drain();

        // last stretch with no idling
        write_seed(32'd1);
        calm = 1'b1;
        random_phase(320);
        drain();

        if (errors == 0)
            $display("** mt19937_ranged_integer_rng_unit: PASSED **");
        else
            $display("** mt19937_ranged_integer_rng_unit: FAILED **");
        $finish;
    end

endmodule
